// ----- design/psc_pkg.sv -----
package psc_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_CMD         = 2'd0;
    localparam logic [1:0] OP_REPLY       = 2'd1;
    localparam logic [1:0] OP_POWER       = 2'd2;
    localparam logic [1:0] OP_SWITCH_DONE = 2'd3;

    // modes other than a running command (0 to 7)
    localparam logic [3:0] MODE_IDLE = 4'd8;
    localparam logic [3:0] MODE_OFF  = 4'd9;

    // supply switch settings
    localparam logic [7:0] SWITCH_ON  = 8'h11;
    localparam logic [7:0] SWITCH_OFF = 8'h00;

    // last entry of the code byte table
    localparam logic [5:0] CODE_LAST = 6'd42;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] cmd;
        logic [7:0] spi_byte;
        logic       power_on;
        logic       success;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        done_valid;
        logic [15:0] result_word;
        logic        switch_valid;
        logic [7:0]  switch_value;
        logic        power_done_valid;
        logic        power_ok;
    } result_t;

    // code bytes sent to the sensor, all runs back to back
    function automatic logic [7:0] code_byte(input logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0, 6'd1, 6'd7, 6'd8, 6'd14, 6'd15, 6'd21, 6'd22,
            6'd28, 6'd29, 6'd33, 6'd34, 6'd38, 6'd39: b = 8'haa;
            6'd3:  b = 8'hea;
            6'd4:  b = 8'h80;
            6'd10: b = 8'heb;
            6'd17: b = 8'hec;
            6'd18: b = 8'h80;
            6'd24: b = 8'hed;
            6'd31: b = 8'hf4;
            6'd36: b = 8'hf2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // first table entry of each command's run
    function automatic logic [5:0] run_start(input logic [2:0] cmd);
        logic [5:0] s;
        s = 6'd0;
        case (cmd)
            3'd0: s = 6'd0;
            3'd1: s = 6'd7;
            3'd2: s = 6'd14;
            3'd3: s = 6'd21;
            3'd4: s = 6'd28;
            3'd5: s = 6'd33;
            3'd6: s = 6'd38;
            default: s = 6'd41;
        endcase
        return s;
    endfunction

    // number of code bytes in each command's run
    function automatic logic [2:0] run_length(input logic [2:0] cmd);
        logic [2:0] n;
        n = 3'd0;
        case (cmd)
            3'd0, 3'd1, 3'd2, 3'd3: n = 3'd7;
            3'd4, 3'd5:             n = 3'd5;
            3'd6:                   n = 3'd3;
            default:                n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

// ----- design/psc_in_if.sv -----
interface psc_in_if
    import psc_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/psc_out_if.sv -----
interface psc_out_if
    import psc_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/psc_seq_core.sv -----
module psc_seq_core
    import psc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t res
);

    logic [3:0]  mode_reg, mode_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic [2:0]  left_reg, left_next;
    logic [15:0] word_reg, word_next;

    logic        adv;
    logic [5:0]  ptr_src;
    logic [2:0]  left_src;
    logic [5:0]  idx;

    // decode one word against the sequencer state
    always_comb
    begin
        mode_next = mode_reg;
        ptr_next  = ptr_reg;
        left_next = left_reg;
        word_next = word_reg;
        res       = '0;
        adv       = 1'b0;
        ptr_src   = ptr_reg;
        left_src  = left_reg;
        idx       = 6'd0;

        unique case (item.operation)
            OP_CMD:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    res.accepted = 1'b1;
                    mode_next    = {1'b0, item.cmd};
                    ptr_src      = run_start(item.cmd);
                    left_src     = run_length(item.cmd);
                    adv          = 1'b1;
                end
            end
            OP_REPLY:
            begin
                if (!mode_reg[3])
                begin
                    adv = 1'b1;
                    if (mode_reg[2:0] < 3'd4)
                    begin
                        // calibration word: 3 + 8 + 5 bits
                        case (left_reg)
                            3'd2:    word_next = {13'd0, item.spi_byte[2:0]};
                            3'd1:    word_next = {word_reg[7:0], item.spi_byte};
                            3'd0:    word_next = {word_reg[10:0], item.spi_byte[7:3]};
                            default: word_next = word_reg;
                        endcase
                    end
                    else
                    begin
                        // data word: high byte then low byte
                        case (left_reg)
                            3'd1:    word_next = {item.spi_byte, 8'h00};
                            3'd0:    word_next = word_reg | {8'h00, item.spi_byte};
                            default: word_next = word_reg;
                        endcase
                    end
                end
            end
            OP_POWER:
            begin
                if (!item.power_on && mode_reg == MODE_IDLE)
                begin
                    res.accepted     = 1'b1;
                    res.switch_valid = 1'b1;
                    res.switch_value = SWITCH_OFF;
                end
                else if (item.power_on && mode_reg == MODE_OFF)
                begin
                    res.accepted     = 1'b1;
                    res.switch_valid = 1'b1;
                    res.switch_value = SWITCH_ON;
                end
            end
            OP_SWITCH_DONE:
            begin
                if (mode_reg == MODE_OFF)
                    mode_next = MODE_IDLE;
                else if (mode_reg == MODE_IDLE)
                    mode_next = MODE_OFF;
                res.power_done_valid = 1'b1;
                res.power_ok         = item.success;
            end
            default:
            begin
                res = '0;
            end
        endcase

        // send the next code byte or finish the command
        if (adv)
        begin
            if (left_src != 3'd0)
            begin
                idx            = (ptr_src > CODE_LAST) ? CODE_LAST : ptr_src;
                res.send_valid = 1'b1;
                res.send_byte  = code_byte(idx);
                ptr_next       = ptr_src + 6'd1;
                left_next      = left_src - 3'd1;
            end
            else
            begin
                mode_next       = MODE_IDLE;
                res.done_valid  = 1'b1;
                res.result_word = word_next;
            end
        end
    end

    // sequencer state, advanced once per word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            ptr_reg  <= 6'd0;
            left_reg <= 3'd0;
            word_reg <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            ptr_reg  <= ptr_next;
            left_reg <= left_next;
            word_reg <= word_next;
        end
    end

endmodule

// ----- design/pressure_sensor_command_sequencer.sv -----
// an accepted word passes the input register, then the result register, on its way to rsp
// throughput: one word per cycle while rsp takes results, the core state updating once per word
// a word sits in the input register while a result waits, so req stays open one deep
// reset: asynchronous, active low; the sequencer starts powered off, pointer,
// count and reply word cleared, both pipeline registers empty
module pressure_sensor_command_sequencer
    import psc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    psc_in_if.sink    req,
    psc_out_if.source rsp
);

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;

    logic    out_free;
    logic    fire;
    logic    take;
    result_t core_res;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign take      = req.valid && req.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= req.data;
    end

    psc_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s1_item_reg),
        .res   (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= core_res;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // a word never both sends a code byte and finishes its command
    a_send_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.send_valid && rsp.data.done_valid))
        else $error("send and done in one result word");

    // a switch write only follows an accepted power request
    a_switch_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.switch_valid) |-> rsp.data.accepted)
        else $error("switch write without acceptance");

    // power flag only with power done
    a_power_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.power_ok) |-> rsp.data.power_done_valid)
        else $error("power_ok without power done");

    // a word held in the input register moves on once the result side is free
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("word lost between input and result register");

endmodule

// ----- verif/psc_result_check.sv -----
`timescale 1ns / 1ps

module psc_result_check
    import psc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    psc_in_if          req,
    psc_out_if         rsp,
    output int         fails,
    output int         pending,
    output logic [3:0] seq_mode,
    output int         words_done,
    output int         power_events
);

    // code bytes of all command runs, entry 0 in the top byte
    localparam logic [43*8-1:0] CODE_BYTES = {
        8'haa, 8'haa, 8'h00, 8'hea, 8'h80, 8'h00, 8'h00,
        8'haa, 8'haa, 8'h00, 8'heb, 8'h00, 8'h00, 8'h00,
        8'haa, 8'haa, 8'h00, 8'hec, 8'h80, 8'h00, 8'h00,
        8'haa, 8'haa, 8'h00, 8'hed, 8'h00, 8'h00, 8'h00,
        8'haa, 8'haa, 8'h00, 8'hf4, 8'h00,
        8'haa, 8'haa, 8'h00, 8'hf2, 8'h00,
        8'haa, 8'haa, 8'h00,
        8'h00, 8'h00
    };
    localparam int CODE_COUNT = 43;

    // run length per command, command 0 in the low bits
    localparam logic [23:0] RUN_LENS = {
        3'd2, 3'd3, 3'd5, 3'd5, 3'd7, 3'd7, 3'd7, 3'd7
    };

    // sequencer state as predicted
    logic [3:0]  mode_q = MODE_OFF;
    logic [5:0]  ptr_q = '0;
    logic [2:0]  left_q = '0;
    logic [15:0] word_q = '0;

    result_t expected_results[$];
    int error_count = 0;
    int open_count = 0;
    int done_count = 0;
    int power_count = 0;

    assign fails = error_count;
    assign pending = open_count;
    assign seq_mode = mode_q;
    assign words_done = done_count;
    assign power_events = power_count;

    function automatic logic [7:0] code_at(input logic [5:0] idx);
        int i;
        i = (idx < 6'(CODE_COUNT)) ? int'(idx) : CODE_COUNT - 1;
        return CODE_BYTES[(CODE_COUNT - 1 - i) * 8 +: 8];
    endfunction

    function automatic logic [2:0] run_len(input logic [2:0] c);
        return RUN_LENS[int'(c) * 3 +: 3];
    endfunction

    // a run starts where the runs of all lower commands end
    function automatic logic [5:0] run_first(input logic [2:0] c);
        logic [5:0] s;
        s = '0;
        for (int k = 0; k < int'(c); k++)
            s = s + 6'(run_len(3'(k)));
        return s;
    endfunction

    // next code byte out, or the finished word when the run is spent
    task automatic advance_run(inout result_t r);
        if (left_q != 3'd0) begin
            r.send_valid = 1'b1;
            r.send_byte = code_at(ptr_q);
            ptr_q = ptr_q + 6'd1;
            left_q = left_q - 3'd1;
        end
        else begin
            mode_q = MODE_IDLE;
            r.done_valid = 1'b1;
            r.result_word = word_q;
        end
    endtask

    task automatic predict_word(input item_t w, output result_t r);
        r = '0;
        case (w.operation)
            OP_CMD:
            begin
                if (mode_q == MODE_IDLE) begin
                    mode_q = {1'b0, w.cmd};
                    ptr_q = run_first(w.cmd);
                    left_q = run_len(w.cmd);
                    r.accepted = 1'b1;
                    advance_run(r);
                end
            end
            OP_REPLY:
            begin
                if (mode_q < MODE_IDLE) begin
                    // calibration words pack 3 + 8 + 5 bits, data words take two bytes
                    if (mode_q < 4'd4) begin
                        if (left_q == 3'd2)
                            word_q = {13'd0, w.spi_byte[2:0]};
                        else if (left_q == 3'd1)
                            word_q = {word_q[7:0], w.spi_byte};
                        else if (left_q == 3'd0)
                            word_q = {word_q[10:0], w.spi_byte[7:3]};
                    end
                    else begin
                        if (left_q == 3'd1)
                            word_q = {w.spi_byte, 8'h00};
                        else if (left_q == 3'd0)
                            word_q = word_q | {8'h00, w.spi_byte};
                    end
                    advance_run(r);
                end
            end
            OP_POWER:
            begin
                if (!w.power_on && mode_q == MODE_IDLE) begin
                    r.accepted = 1'b1;
                    r.switch_valid = 1'b1;
                    r.switch_value = SWITCH_OFF;
                end
                else if (w.power_on && mode_q == MODE_OFF) begin
                    r.accepted = 1'b1;
                    r.switch_valid = 1'b1;
                    r.switch_value = SWITCH_ON;
                end
            end
            default:
            begin
                // switch done flips off and idle, a running command keeps its mode
                if (mode_q == MODE_OFF)
                    mode_q = MODE_IDLE;
                else if (mode_q == MODE_IDLE)
                    mode_q = MODE_OFF;
                r.power_done_valid = 1'b1;
                r.power_ok = w.success;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // compare finished words, then predict the newly taken one
    always @(posedge clk or negedge rst_n) begin : watch
        result_t fresh;
        result_t want;
        result_t got;
        if (!rst_n) begin
            mode_q = MODE_OFF;
            ptr_q = '0;
            left_q = '0;
            word_q = '0;
            expected_results.delete();
            open_count = 0;
        end
        else begin
            if (rsp.valid && rsp.ready) begin
                got = rsp.data;
                if (expected_results.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    error_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("accepted", 16'(want.accepted), 16'(got.accepted));
                    check_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
                    check_field("send_byte", 16'(want.send_byte), 16'(got.send_byte));
                    check_field("done_valid", 16'(want.done_valid), 16'(got.done_valid));
                    check_field("result_word", want.result_word, got.result_word);
                    check_field("switch_valid", 16'(want.switch_valid),
                                16'(got.switch_valid));
                    check_field("switch_value", 16'(want.switch_value),
                                16'(got.switch_value));
                    check_field("power_done_valid", 16'(want.power_done_valid),
                                16'(got.power_done_valid));
                    check_field("power_ok", 16'(want.power_ok), 16'(got.power_ok));
                    if (want.done_valid)
                        done_count++;
                    if (want.power_done_valid)
                        power_count++;
                end
            end
            if (req.valid && req.ready) begin
                predict_word(req.data, fresh);
                expected_results.push_back(fresh);
            end
            open_count = expected_results.size();
        end
    end

endmodule

// ----- verif/pressure_sensor_command_sequencer_test.sv -----
`timescale 1ns / 1ps

module pressure_sensor_command_sequencer_test;
    import psc_pkg::*;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   words_done;
    int   power_events;
    int   words_sent = 0;
    logic [3:0] seq_mode;
    bit   steady = 1'b0;
    bit   hold_go = 1'b0;

    psc_in_if  req();
    psc_out_if rsp();

    pressure_sensor_command_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    psc_result_check check_u (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fails        (fails),
        .pending      (pending),
        .seq_mode     (seq_mode),
        .words_done   (words_done),
        .power_events (power_events)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_t make_word(input logic [1:0] op, input logic [2:0] c,
                                        input logic [7:0] b, input logic p,
                                        input logic s);
        item_t w;
        w.operation = op;
        w.cmd = c;
        w.spi_byte = b;
        w.power_on = p;
        w.success = s;
        return w;
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic item_t rand_word();
        return make_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    endfunction

    function automatic item_t reply_word();
        return make_word(OP_REPLY, 3'($urandom_range(0, 7)), rand_byte(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic item_t power_word(input logic p);
        return make_word(OP_POWER, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)), p, 1'($urandom_range(0, 1)));
    endfunction

    function automatic item_t switch_word();
        return make_word(OP_SWITCH_DONE, 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    endfunction

    // offer one word from a falling edge, return at the falling edge after it is taken
    task automatic push_word(input item_t w);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data <= w;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        words_sent++;
    endtask

    // receiver: random stalls, one long hold-off once the random part starts
    initial begin : receiver
        int stall;
        bit held;
        held = 1'b0;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_go && !held) begin
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (150) @(negedge clk);
                continue;
            end
            stall = idle_gap();
            if (stall > 0) begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // stimulus
    initial begin : stimulus
        int kind;
        int waited;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // powered off: reply, command and power off all do nothing
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b1, 1'b1));
        push_word(make_word(OP_CMD, 3'd7, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_POWER, 3'd0, 8'h00, 1'b0, 1'b1));
        // switch done with a failed flag still powers up; power on while idle refused
        push_word(make_word(OP_SWITCH_DONE, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_POWER, 3'd7, 8'hff, 1'b1, 1'b0));
        // calibration word with a busy command, power request and switch done inside
        push_word(make_word(OP_CMD, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_CMD, 3'd3, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_POWER, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_SWITCH_DONE, 3'd0, 8'h00, 1'b0, 1'b1));
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b0, 1'b0));
        push_word(make_word(OP_REPLY, 3'd0, 8'hff, 1'b0, 1'b0));
        // shortest data command
        push_word(make_word(OP_CMD, 3'd7, 8'h00, 1'b1, 1'b1));
        push_word(make_word(OP_REPLY, 3'd7, 8'ha5, 1'b1, 1'b1));
        push_word(make_word(OP_REPLY, 3'd7, 8'h5a, 1'b1, 1'b1));
        // power off and back on
        push_word(make_word(OP_POWER, 3'd0, 8'h00, 1'b0, 1'b0));
        push_word(make_word(OP_SWITCH_DONE, 3'd0, 8'h00, 1'b0, 1'b1));
        push_word(make_word(OP_POWER, 3'd0, 8'h00, 1'b1, 1'b0));
        push_word(make_word(OP_SWITCH_DONE, 3'd0, 8'h00, 1'b1, 1'b0));

        // random command runs, power cycles and noise
        hold_go = 1'b1;
        while (words_sent < 520) begin
            if ($urandom_range(0, 19) == 0)
                steady = ~steady;
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                push_word(rand_word());
            end
            else if (seq_mode == MODE_OFF) begin
                if (kind < 90)
                    push_word(power_word(1'b1));
                push_word(switch_word());
            end
            else if (seq_mode == MODE_IDLE) begin
                if (kind < 85) begin
                    push_word(make_word(OP_CMD, 3'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
                    while (seq_mode < MODE_IDLE) begin
                        if ($urandom_range(0, 19) == 0)
                            push_word(rand_word());
                        else
                            push_word(reply_word());
                    end
                end
                else begin
                    push_word(power_word(1'b0));
                    push_word(switch_word());
                end
            end
            else begin
                // a run left open by noise gets finished
                push_word(reply_word());
            end
        end
        req.valid <= 1'b0;

        // drain
        waited = 0;
        while (pending != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);

        $display("sent %0d input words: %0d command words finished, %0d power changes seen",
                 words_sent, words_done, power_events);
        $display("all commands, power requests, switch completions and busy refusals exercised");
        if (fails == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- pressure_sensor_command_sequencer.f -----
design/psc_pkg.sv
design/psc_in_if.sv
design/psc_out_if.sv
design/psc_seq_core.sv
design/pressure_sensor_command_sequencer.sv
verif/psc_result_check.sv
verif/pressure_sensor_command_sequencer_test.sv
